@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the list node manager RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define CLNM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also active during reset
`define CLNM_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/clnm_pkg.sv @@
// Package for the cursor list node manager: request/response word types,
// opcodes and status codes. No dependencies.
`default_nettype none
package clnm_pkg;

   localparam int POS_W = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_MERGE  = 2'd2,
      OP_READ   = 2'd3
   } op_code_type;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_NOSUCC = 2'd2;

   localparam logic signed [7:0] NODE_NONE = 8'shFF;

   typedef struct packed {
      op_code_type        req_type;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   second_position;
      logic signed [31:0] value;
   } clnm_req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [7:0]  node;
      logic signed [31:0] element_out;
      logic signed [7:0]  next_out;
   } clnm_rsp_word_type;

endpackage
`default_nettype wire

@@ rtl/core/clnm_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// Read-first on a same-address collision. No dependencies.
`default_nettype none
module clnm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/clnm_seq.sv @@
// Sequencer of the list node manager: runs each request as a series of
// read/modify/write steps on the link and element RAMs. Uses clnm_pkg.
`default_nettype none
module clnm_seq #(
   parameter int NODES         = 128,
   parameter int ELEMENT_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  clnm_pkg::op_code_type                  op_in,
   input  wire logic [$clog2(NODES)-1:0]          p_in,
   input  wire logic [$clog2(NODES)-1:0]          h_in,
   input  wire logic [ELEMENT_WIDTH-1:0]          val_in,
   output logic                                   ready,
   output logic                                   res_valid,
   input  wire logic                              res_taken,
   output clnm_pkg::clnm_rsp_word_type            res_data,
   output logic                                   link_rd_en,
   output logic [$clog2(NODES)-1:0]               link_rd_addr,
   input  wire logic [$clog2(NODES):0]            link_rd_data,
   output logic                                   link_wr_en,
   output logic [$clog2(NODES)-1:0]               link_wr_addr,
   output logic [$clog2(NODES):0]                 link_wr_data,
   output logic                                   elem_rd_en,
   input  wire logic [ELEMENT_WIDTH-1:0]          elem_rd_data,
   output logic                                   elem_wr_en,
   output logic [$clog2(NODES)-1:0]               elem_wr_addr,
   output logic [ELEMENT_WIDTH-1:0]               elem_wr_data
);
   import clnm_pkg::*;

   localparam int IW = $clog2(NODES);
   localparam int LW = IW + 1;
   localparam int HW = $clog2(NODES + 1);
   localparam int NW = (IW > 8) ? IW : 8;
   localparam int XW = (ELEMENT_WIDTH > 32) ? ELEMENT_WIDTH : 32;
   localparam logic [LW-1:0] LINK_NULL = {1'b1, {IW{1'b0}}};

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      INS_FREE,
      INS_NEXT,
      INS_POS,
      INS_LINK,
      DEL_SUCC,
      DEL_NEXT,
      DEL_FREE,
      MRG_WALK,
      MRG_HDR,
      MRG_FREE,
      RD_DATA,
      ST_OUT
   } state_type;

   state_type         state_ff;
   logic [IW-1:0]     clr_ff;
   logic [IW-1:0]     fh_ff;
   logic [IW-1:0]     p_ff;
   logic [IW-1:0]     h_ff;
   logic [IW-1:0]     q_ff;
   logic [IW-1:0]     t_ff;
   logic [HW-1:0]     hops_ff;
   logic [LW-1:0]     lq_ff;
   logic [ELEMENT_WIDTH-1:0] val_ff;
   clnm_rsp_word_type res_ff;

   logic              d_null;
   logic [IW-1:0]     d_idx;
   logic [LW-1:0]     lp_fwd;
   logic              walk_more;
   logic [NW-1:0]     node_wide;
   logic [NW-1:0]     next_wide;
   logic signed [XW-1:0] elem_ext;

   assign d_null    = link_rd_data[IW];
   assign d_idx     = link_rd_data[IW-1:0];
   assign lp_fwd    = (p_ff == fh_ff) ? lq_ff : link_rd_data;
   assign walk_more = !d_null && (hops_ff != HW'(NODES - 1));
   assign node_wide = NW'(p_ff);
   assign next_wide = NW'(d_idx);
   assign elem_ext  = XW'(signed'(elem_rd_data));

   assign ready     = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_OUT);
   assign res_data  = res_ff;

   always_comb begin
      link_rd_en   = 1'b0;
      link_rd_addr = p_in;
      link_wr_en   = 1'b0;
      link_wr_addr = p_ff;
      link_wr_data = lp_fwd;
      elem_rd_en   = 1'b0;
      elem_wr_en   = 1'b0;
      elem_wr_addr = q_ff;
      elem_wr_data = val_ff;
      case (state_ff)
         ST_CLEAR: begin
            link_wr_en   = 1'b1;
            link_wr_addr = clr_ff;
            link_wr_data = (clr_ff == IW'(NODES - 1)) ? LINK_NULL : {1'b0, clr_ff + 1'b1};
            elem_wr_en   = 1'b1;
            elem_wr_addr = clr_ff;
            elem_wr_data = '0;
         end
         ST_IDLE: begin
            link_rd_en   = start;
            link_rd_addr = (op_in == OP_INSERT) ? fh_ff : p_in;
            elem_rd_en   = start && (op_in == OP_READ);
         end
         INS_FREE: begin
            link_rd_en   = !d_null;
            link_rd_addr = d_idx;
         end
         INS_NEXT: begin
            link_wr_en   = 1'b1;
            link_wr_addr = fh_ff;
            link_wr_data = link_rd_data;
            elem_wr_en   = 1'b1;
            link_rd_en   = 1'b1;
            link_rd_addr = p_ff;
         end
         INS_POS: begin
            link_wr_en   = 1'b1;
            link_wr_addr = q_ff;
            link_wr_data = lp_fwd;
         end
         INS_LINK: begin
            link_wr_en   = 1'b1;
            link_wr_addr = p_ff;
            link_wr_data = {1'b0, q_ff};
         end
         DEL_SUCC: begin
            link_rd_en   = !d_null;
            link_rd_addr = d_idx;
         end
         DEL_NEXT: begin
            link_wr_en   = 1'b1;
            link_wr_addr = p_ff;
            link_wr_data = link_rd_data;
         end
         DEL_FREE: begin
            link_wr_en   = 1'b1;
            link_wr_addr = q_ff;
            link_wr_data = {1'b0, fh_ff};
         end
         MRG_WALK: begin
            link_rd_en   = 1'b1;
            link_rd_addr = walk_more ? d_idx : h_ff;
         end
         MRG_HDR: begin
            link_wr_en   = 1'b1;
            link_wr_addr = t_ff;
            link_wr_data = link_rd_data;
         end
         MRG_FREE: begin
            link_wr_en   = 1'b1;
            link_wr_addr = h_ff;
            link_wr_data = {1'b0, fh_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         fh_ff    <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IW'(NODES - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  p_ff    <= p_in;
                  h_ff    <= h_in;
                  t_ff    <= p_in;
                  val_ff  <= val_in;
                  hops_ff <= '0;
                  res_ff.status      <= STATUS_OK;
                  res_ff.node        <= NODE_NONE;
                  res_ff.element_out <= '0;
                  res_ff.next_out    <= NODE_NONE;
                  case (op_in)
                     OP_INSERT: state_ff <= INS_FREE;
                     OP_DELETE: state_ff <= DEL_SUCC;
                     OP_MERGE:  state_ff <= MRG_WALK;
                     default:   state_ff <= RD_DATA;
                  endcase
               end
            end
            INS_FREE: begin
               q_ff <= d_idx;
               if (d_null) begin
                  res_ff.status <= STATUS_FULL;
                  state_ff      <= ST_OUT;
               end else begin
                  state_ff <= INS_NEXT;
               end
            end
            INS_NEXT: begin
               lq_ff    <= link_rd_data;
               state_ff <= INS_POS;
            end
            INS_POS: begin
               state_ff <= INS_LINK;
            end
            INS_LINK: begin
               res_ff.node <= signed'(NW'(q_ff) & NW'(8'hFF));
               state_ff    <= ST_OUT;
            end
            DEL_SUCC: begin
               q_ff <= d_idx;
               if (d_null) begin
                  res_ff.status <= STATUS_NOSUCC;
                  state_ff      <= ST_OUT;
               end else begin
                  state_ff <= DEL_NEXT;
               end
            end
            DEL_NEXT: begin
               state_ff <= DEL_FREE;
            end
            DEL_FREE: begin
               fh_ff       <= q_ff;
               res_ff.node <= signed'(NW'(q_ff) & NW'(8'hFF));
               state_ff    <= ST_OUT;
            end
            MRG_WALK: begin
               if (!d_null) begin
                  t_ff    <= d_idx;
                  hops_ff <= hops_ff + 1'b1;
               end
               if (!walk_more) begin
                  state_ff <= MRG_HDR;
               end
            end
            MRG_HDR: begin
               state_ff <= MRG_FREE;
            end
            MRG_FREE: begin
               fh_ff       <= h_ff;
               res_ff.node <= signed'(NW'(h_ff) & NW'(8'hFF));
               state_ff    <= ST_OUT;
            end
            RD_DATA: begin
               res_ff.node        <= node_wide[7:0];
               res_ff.element_out <= elem_ext[31:0];
               res_ff.next_out    <= d_null ? NODE_NONE : next_wide[7:0];
               state_ff           <= ST_OUT;
            end
            ST_OUT: begin
               if (res_taken) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/cursor_list_node_manager_top.sv @@
// One request in flight; the next is taken the cycle after the result moves
// to the output register, which holds it until rsp_ready.
// After reset the link and element RAMs are initialized in ST_CLEAR,
// with req_ready low; each node then links to the next, the last is null.
`default_nettype none
`include "assert_macros.svh"
module cursor_list_node_manager_top #(
   parameter int NODES         = 128,
   parameter int ELEMENT_WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  clnm_pkg::clnm_req_word_type      req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output clnm_pkg::clnm_rsp_word_type      rsp_data
);
   import clnm_pkg::*;

   localparam int IW = $clog2(NODES);
   localparam int LW = IW + 1;
   localparam int PN = 2 ** POS_W;
   localparam int VW = (ELEMENT_WIDTH > 32) ? ELEMENT_WIDTH : 32;

   logic [IW-1:0] mod_tbl [PN];
   logic [IW-1:0] p_idx;
   logic [IW-1:0] h_idx;
   logic [VW-1:0] val_wide;
   logic          start;

   logic              res_valid;
   logic              res_taken;
   clnm_rsp_word_type res_data;
   logic              rsp_valid_ff;
   clnm_rsp_word_type rsp_data_ff;

   logic                     link_rd_en;
   logic [IW-1:0]            link_rd_addr;
   logic [LW-1:0]            link_rd_data;
   logic                     link_wr_en;
   logic [IW-1:0]            link_wr_addr;
   logic [LW-1:0]            link_wr_data;
   logic                     elem_rd_en;
   logic [ELEMENT_WIDTH-1:0] elem_rd_data;
   logic                     elem_wr_en;
   logic [IW-1:0]            elem_wr_addr;
   logic [ELEMENT_WIDTH-1:0] elem_wr_data;

   for (genvar i = 0; i < PN; i++) begin : g_mod
      assign mod_tbl[i] = IW'(i % NODES);
   end

   assign p_idx    = mod_tbl[req_data.position];
   assign h_idx    = mod_tbl[req_data.second_position];
   assign val_wide = VW'($unsigned(req_data.value));
   assign start    = req_valid && req_ready;

   assign res_taken = res_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (res_taken) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res_data;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   clnm_seq #(
      .NODES        (NODES),
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .op_in       (req_data.req_type),
      .p_in        (p_idx),
      .h_in        (h_idx),
      .val_in      (val_wide[ELEMENT_WIDTH-1:0]),
      .ready       (req_ready),
      .res_valid   (res_valid),
      .res_taken   (res_taken),
      .res_data    (res_data),
      .link_rd_en  (link_rd_en),
      .link_rd_addr(link_rd_addr),
      .link_rd_data(link_rd_data),
      .link_wr_en  (link_wr_en),
      .link_wr_addr(link_wr_addr),
      .link_wr_data(link_wr_data),
      .elem_rd_en  (elem_rd_en),
      .elem_rd_data(elem_rd_data),
      .elem_wr_en  (elem_wr_en),
      .elem_wr_addr(elem_wr_addr),
      .elem_wr_data(elem_wr_data)
   );

   clnm_ram #(
      .WIDTH(LW),
      .DEPTH(NODES)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (link_wr_en),
      .wr_addr(link_wr_addr),
      .wr_data(link_wr_data),
      .rd_en  (link_rd_en),
      .rd_addr(link_rd_addr),
      .rd_data(link_rd_data)
   );

   clnm_ram #(
      .WIDTH(ELEMENT_WIDTH),
      .DEPTH(NODES)
   ) u_elem_ram (
      .clock  (clock),
      .wr_en  (elem_wr_en),
      .wr_addr(elem_wr_addr),
      .wr_data(elem_wr_data),
      .rd_en  (elem_rd_en),
      .rd_addr(link_rd_addr),
      .rd_data(elem_rd_data)
   );

   `CLNM_ASSERT(a_one_in_flight, clock, reset, start |=> !req_ready,
      "request accepted while another is in flight")
   `CLNM_ASSERT(a_fail_no_node, clock, reset,
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.node == NODE_NONE,
      "failed request reports a node")
   `CLNM_ASSERT(a_rsp_from_seq, clock, reset, $rose(rsp_valid) |-> $past(res_valid),
      "response appeared without a sequencer result")
   `CLNM_ASSERT_NR(a_reset_clears, clock, reset |=> !rsp_valid && !req_ready,
      "response or ready active right after reset")

endmodule
`default_nettype wire

@@ test/cursor_list_node_manager_top_tb.sv @@
// Testbench for cursor_list_node_manager_top: a directed table, then rounds of random words.
// Typed rows or a list predictor check each response word. Needs clnm_pkg and the top level.
`timescale 1ns / 1ps
module cursor_list_node_manager_top_tb;
   import clnm_pkg::*;

   localparam int NODE_COUNT  = 128;
   localparam int ROUNDS      = 6;
   localparam int ROUND_WORDS = 255;
   localparam int LONG_HOLD   = 400;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 150;

   typedef struct {
      clnm_req_word_type word;
      bit                typed;
      clnm_rsp_word_type rsp;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   clnm_req_word_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   clnm_rsp_word_type rsp_data;

   logic signed [7:0]  link_mem [NODE_COUNT];
   logic signed [31:0] elem_mem [NODE_COUNT];
   int                 free_head;
   int                 live_nodes [$];

   clnm_rsp_word_type node_result_q [$];
   clnm_rsp_word_type want;
   table_row_type     directed_rows [$];
   int                error_count = 0;
   int                idle_cycles = 0;
   bit                long_hold_req = 1'b0;
   bit                quiet_round = 1'b0;

   cursor_list_node_manager_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void reset_list_model();
      for (int i = 0; i < NODE_COUNT; i++) begin
         link_mem[i] = (i + 1 < NODE_COUNT) ? 8'(i + 1) : NODE_NONE;
         elem_mem[i] = '0;
      end
      free_head = 0;
   endfunction

   function automatic clnm_rsp_word_type apply_list_op(input clnm_req_word_type w);
      clnm_rsp_word_type r;
      int p;
      int hdr;
      int q;
      int t;
      int hops;
      r.status      = STATUS_OK;
      r.node        = NODE_NONE;
      r.element_out = '0;
      r.next_out    = NODE_NONE;
      p   = int'(w.position);
      hdr = int'(w.second_position);
      case (w.req_type)
         OP_INSERT: begin
            if (link_mem[free_head] == NODE_NONE) begin
               r.status = STATUS_FULL;
            end else begin
               q = int'(link_mem[free_head]);
               link_mem[free_head] = link_mem[q];
               elem_mem[q] = w.value;
               link_mem[q] = link_mem[p];
               link_mem[p] = 8'(q);
               r.node = 8'(q);
            end
         end
         OP_DELETE: begin
            if (link_mem[p] == NODE_NONE) begin
               r.status = STATUS_NOSUCC;
            end else begin
               q = int'(link_mem[p]);
               link_mem[p] = link_mem[q];
               link_mem[q] = 8'(free_head);
               free_head = q;
               r.node = 8'(q);
            end
         end
         OP_MERGE: begin
            t = p;
            hops = 0;
            while (link_mem[t] != NODE_NONE && hops < NODE_COUNT) begin
               t = int'(link_mem[t]);
               hops++;
            end
            link_mem[t] = link_mem[hdr];
            link_mem[hdr] = 8'(free_head);
            free_head = hdr;
            r.node = 8'(hdr);
         end
         default: begin
            r.node        = 8'(p);
            r.element_out = elem_mem[p];
            r.next_out    = link_mem[p];
         end
      endcase
      return r;
   endfunction

   // nodes not reachable from the free head
   function automatic void refresh_live_nodes();
      bit on_free [NODE_COUNT];
      int n;
      int steps;
      foreach (on_free[i]) on_free[i] = 1'b0;
      n = free_head;
      on_free[n] = 1'b1;
      steps = 0;
      while (link_mem[n] != NODE_NONE && steps < NODE_COUNT) begin
         n = int'(link_mem[n]);
         if (on_free[n]) break;
         on_free[n] = 1'b1;
         steps++;
      end
      live_nodes.delete();
      for (int i = 0; i < NODE_COUNT; i++) begin
         if (!on_free[i]) live_nodes.push_back(i);
      end
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // even rounds grow the lists, odd rounds shrink them; late rounds add merges and noise
   function automatic clnm_req_word_type make_request(input int round_idx);
      clnm_req_word_type w;
      int pick;
      bit late;
      late = (round_idx >= 4);
      w.req_type        = op_code_type'(2'($urandom_range(0, 3)));
      w.position        = 7'($urandom);
      w.second_position = 7'($urandom);
      w.value           = $urandom;
      if (late && $urandom_range(0, 99) < 12) return w;
      refresh_live_nodes();
      if (live_nodes.size() == 0) begin
         w.req_type = OP_INSERT;
         if (link_mem[free_head] != NODE_NONE) w.position = link_mem[free_head][6:0];
         return w;
      end
      w.position        = 7'(live_nodes[$urandom_range(0, live_nodes.size() - 1)]);
      w.second_position = 7'(live_nodes[$urandom_range(0, live_nodes.size() - 1)]);
      pick = $urandom_range(0, 99);
      if (round_idx % 2 == 0) begin
         if (pick < 55) w.req_type = OP_INSERT;
         else if (pick < 75) w.req_type = OP_DELETE;
         else if (pick < 90 || !late) w.req_type = OP_READ;
         else w.req_type = OP_MERGE;
      end else begin
         if (pick < 20) w.req_type = OP_INSERT;
         else if (pick < 70) w.req_type = OP_DELETE;
         else if (pick < 85 || !late) w.req_type = OP_READ;
         else w.req_type = OP_MERGE;
      end
      return w;
   endfunction

   function automatic void add_row(input op_code_type op, input int pos, input int pos2,
                                   input logic [31:0] v, input bit typed,
                                   input logic [1:0] st, input int nd,
                                   input logic [31:0] el, input int nx);
      table_row_type row;
      row.word.req_type        = op;
      row.word.position        = 7'(pos);
      row.word.second_position = 7'(pos2);
      row.word.value           = v;
      row.typed                = typed;
      row.rsp.status           = st;
      row.rsp.node             = 8'(nd);
      row.rsp.element_out      = el;
      row.rsp.next_out         = 8'(nx);
      directed_rows.push_back(row);
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic issue_word(input clnm_req_word_type w, input bit typed,
                             input clnm_rsp_word_type typed_rsp, input int gap);
      clnm_rsp_word_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_list_op(w);
      node_result_q.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (node_result_q.size() == 0) begin
            report_error("response word with nothing pending");
         end else begin
            want = node_result_q.pop_front();
            if (rsp_data.status !== want.status)
               report_error($sformatf("status %0d, want %0d", rsp_data.status, want.status));
            if (rsp_data.node !== want.node)
               report_error($sformatf("node %0d, want %0d", rsp_data.node, want.node));
            if (rsp_data.element_out !== want.element_out)
               report_error($sformatf("element_out %h, want %h",
                                      rsp_data.element_out, want.element_out));
            if (rsp_data.next_out !== want.next_out)
               report_error($sformatf("next_out %0d, want %0d",
                                      rsp_data.next_out, want.next_out));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int  stall_left;
      bit  long_hold_done;
      stall_left = 0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !long_hold_done) begin
            stall_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_round && $urandom_range(0, 99) < 30) stall_left = gap_len();
         end
      end
   end

   initial begin
      clnm_req_word_type w;
      clnm_rsp_word_type unused_rsp;
      int                gap;
      unused_rsp = '0;
      reset_list_model();
      // read back reset links, then the extremes, no-successor and tail deletion
      add_row(OP_READ,     0,   0, 32'h0,         1, STATUS_OK,     0,   32'h0,         1);
      add_row(OP_READ,   127, 127, 32'h0,         1, STATUS_OK,     127, 32'h0,        -1);
      add_row(OP_DELETE, 127,   0, 32'h0,         1, STATUS_NOSUCC, -1,  32'h0,        -1);
      add_row(OP_INSERT, 127, 127, 32'h7FFF_FFFF, 1, STATUS_OK,     1,   32'h0,        -1);
      add_row(OP_READ,     1,   0, 32'h0,         1, STATUS_OK,     1,   32'h7FFF_FFFF, -1);
      add_row(OP_INSERT,   5,   0, 32'h8000_0000, 1, STATUS_OK,     2,   32'h0,        -1);
      add_row(OP_READ,     2,   0, 32'h0,         1, STATUS_OK,     2,   32'h8000_0000, 6);
      add_row(OP_DELETE,   5,   0, 32'h0,         1, STATUS_OK,     2,   32'h0,        -1);
      add_row(OP_DELETE, 127,   0, 32'h0,         1, STATUS_OK,     1,   32'h0,        -1);
      add_row(OP_READ,   127,   0, 32'h0,         1, STATUS_OK,     127, 32'h0,        -1);
      // self-linked node, two-node ring, then a merge that runs out its walk
      add_row(OP_INSERT,   2,   0, 32'h5,         0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_INSERT,   2, 127, 32'hFFFF_FFFF, 0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_MERGE,    2,   0, 32'h0,         0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_READ,     0,   0, 32'h0,         0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_READ,     2,   0, 32'h0,         0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_INSERT,   2,   0, 32'h5555_5555, 0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_INSERT,   1,   0, 32'hAAAA_AAAA, 0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_DELETE,   2, 127, 32'h0,         0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_MERGE,    3,   2, 32'h0,         0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_READ,     3,   0, 32'h0,         0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_INSERT,   3,   0, 32'h0,         0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_READ,     3,   0, 32'h0,         0, STATUS_OK, 0, 32'h0, 0);
      add_row(OP_READ,   126,   0, 32'h0,         0, STATUS_OK, 0, 32'h0, 0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         gap = ($urandom_range(0, 99) < 50) ? 0 : gap_len();
         issue_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].rsp, gap);
      end

      for (int round_idx = 0; round_idx < ROUNDS; round_idx++) begin
         // let every pending response drain before each round
         req_valid <= 1'b0;
         do @(negedge clock); while (node_result_q.size() != 0);
         quiet_round = (round_idx == 3);
         if (round_idx == 1) long_hold_req = 1'b1;
         for (int k = 0; k < ROUND_WORDS; k++) begin
            gap = (quiet_round || $urandom_range(0, 99) < 50) ? 0 : gap_len();
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            w = make_request(round_idx);
            issue_word(w, 1'b0, unused_rsp, 0);
         end
      end

      req_valid <= 1'b0;
      while (node_result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/clnm_pkg.sv
rtl/core/clnm_ram.sv
rtl/core/clnm_seq.sv
rtl/core/cursor_list_node_manager_top.sv
test/cursor_list_node_manager_top_tb.sv
